/* rtl/unc_pkg.sv */
// Shared types, constants and helpers for the UTF-16 newline converter.
`timescale 1ns / 1ps
`default_nettype none
package unc_pkg;

	// Newline convention codes
	localparam logic [1:0] OS_WIN  = 2'd0;
	localparam logic [1:0] OS_MAC  = 2'd1;
	localparam logic [1:0] OS_UNIX = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_SOURCE_OS  = 2'd0;
	localparam logic [1:0] REG_DEST_OS    = 2'd1;
	localparam logic [1:0] REG_SWAP_BYTES = 2'd2;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Unit patterns: the BOM in big-endian order, CR and LF in both byte orders
	localparam logic [15:0] BOM_BE   = 16'hFEFF;
	localparam logic [15:0] CR_BE    = 16'h000D;
	localparam logic [15:0] CR_LE    = 16'h0D00;
	localparam logic [15:0] LF_BE    = 16'h000A;
	localparam logic [15:0] LF_LE    = 16'h0A00;

	// Command queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0] source_os;
		logic [1:0] dest_os;
		logic       swap_bytes;
	} cfg_t;

	// One queued command: one or two finished output units
	typedef struct packed {
		logic        two;
		logic [15:0] unit0;
		logic [15:0] unit1;
	} cmd_t;

	// Unused code 3 behaves as unix
	function automatic logic [1:0] os_code(input logic [1:0] v);
		return (v == 2'd3) ? OS_UNIX : v;
	endfunction

	function automatic logic [15:0] out_form(input logic [15:0] u, input logic swap);
		return swap ? {u[7:0], u[15:8]} : u;
	endfunction

endpackage
`default_nettype wire

/* rtl/unc_front.sv */
// Front end: takes items, tracks stream state and builds output commands.
`timescale 1ns / 1ps
`default_nettype none
module unc_front
	import unc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] code_unit,
	input  wire logic        end_of_stream,
	input  wire logic        q_full,
	output logic             q_push,
	output cmd_t             q_cmd
);

	logic        bom_seen_q, big_endian_q, cr_held_q;
	logic        bom_d, be_d, crh_d;
	logic        emit, two;
	logic [15:0] a, b, cr, lf, u;
	logic [1:0]  src, dst;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign u        = code_unit;
	assign src      = os_code(cfg.source_os);
	assign dst      = os_code(cfg.dest_os);
	assign cr       = big_endian_q ? CR_BE : CR_LE;
	assign lf       = big_endian_q ? LF_BE : LF_LE;

	always_comb begin
		emit  = 1'b0;
		two   = 1'b0;
		a     = u;
		b     = lf;
		bom_d = bom_seen_q;
		be_d  = big_endian_q;
		crh_d = cr_held_q;
		if (end_of_stream) begin
			if (cr_held_q) begin
				emit = 1'b1;
				a    = cr;
			end
			bom_d = 1'b0;
			be_d  = 1'b0;
			crh_d = 1'b0;
		end else if (!bom_seen_q) begin
			bom_d = 1'b1;
			be_d  = (u == BOM_BE);
			emit  = 1'b1;
		end else if (cr_held_q) begin
			if (u == lf) begin
				crh_d = 1'b0;
				emit  = 1'b1;
				unique case (dst)
					OS_WIN: begin
						two = 1'b1;
						a   = cr;
					end
					OS_MAC:  a = cr;
					default: a = lf;
				endcase
			end else if (u == cr && src == OS_WIN && dst != OS_WIN) begin
				// first CR goes out, second one stays held
				emit = 1'b1;
				a    = cr;
			end else begin
				crh_d = 1'b0;
				emit  = 1'b1;
				two   = 1'b1;
				a     = cr;
				b     = u;
			end
		end else if (src == OS_WIN) begin
			if (dst != OS_WIN && u == cr)
				crh_d = 1'b1;
			else
				emit = 1'b1;
		end else if (dst == OS_WIN) begin
			emit = 1'b1;
			if ((src == OS_MAC && u == cr) || (src == OS_UNIX && u == lf)) begin
				two = 1'b1;
				a   = cr;
			end
		end else if (src == OS_MAC && dst == OS_UNIX && u == cr) begin
			emit = 1'b1;
			a    = lf;
		end else if (src == OS_UNIX && dst == OS_MAC && u == lf) begin
			emit = 1'b1;
			a    = cr;
		end else begin
			emit = 1'b1;
		end
	end

	assign q_push      = accept && emit;
	assign q_cmd.two   = two;
	assign q_cmd.unit0 = out_form(a, cfg.swap_bytes);
	assign q_cmd.unit1 = out_form(b, cfg.swap_bytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bom_seen_q   <= 1'b0;
			big_endian_q <= 1'b0;
			cr_held_q    <= 1'b0;
		end else if (accept) begin
			bom_seen_q   <= bom_d;
			big_endian_q <= be_d;
			cr_held_q    <= crh_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/unc_fifo.sv */
// Short command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module unc_fifo
	import unc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty,
	output logic      full
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/unc_back.sv */
// Back end: plays out the one or two units of each queued command.
`timescale 1ns / 1ps
`default_nettype none
module unc_back
	import unc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        head,
	input  wire logic        empty,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      out_unit,
	output logic             last_of_run
);

	logic idx_q;
	logic take;

	assign out_valid   = !empty;
	assign out_unit    = idx_q ? head.unit1 : head.unit0;
	assign last_of_run = !head.two || idx_q;
	assign take        = out_valid && out_ready;
	assign pop         = take && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= 1'b0;
		else if (take)
			idx_q <= !last_of_run;
	end

endmodule
`default_nettype wire

/* rtl/utf16_newline_converter.sv */
// Top level: APB register file, front end, command queue and back end.
// A result item is written to the command queue when its input item is taken
// and is offered after the commands ahead of it. One result item per cycle
// while out_ready is high; an input item causes zero, one or two results.
// A two-entry command queue lets input continue while output stalls, until it fills.
// Reset (arst_n low, asynchronous) clears registers, stream state and queue.
`timescale 1ns / 1ps
`default_nettype none
module utf16_newline_converter
	import unc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [15:0]        code_unit,
	input  wire logic               end_of_stream,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [15:0]        out_unit,
	output logic                    last_of_run
);

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;
	logic       q_push, q_pop, q_empty, q_full;
	cmd_t       q_cmd, q_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SOURCE_OS:  cfg_q.source_os  <= pwdata[1:0];
				REG_DEST_OS:    cfg_q.dest_os    <= pwdata[1:0];
				REG_SWAP_BYTES: cfg_q.swap_bytes <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_SOURCE_OS:  prdata = PDATA_W'(cfg_q.source_os);
			REG_DEST_OS:    prdata = PDATA_W'(cfg_q.dest_os);
			REG_SWAP_BYTES: prdata = PDATA_W'(cfg_q.swap_bytes);
			default:        prdata = '0;
		endcase
	end

	unc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.code_unit     (code_unit),
		.end_of_stream (end_of_stream),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_cmd)
	);

	unc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	unc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.empty       (q_empty),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_unit    (out_unit),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire
